>>> rtl/drs_pkg.sv
// Shared constants, codes and beat types of the disk request order scheduler.
`timescale 1ns / 1ps
`default_nettype none
package drs_pkg;

    // Store geometry and field widths.
    localparam int MaxReq  = 32;
    localparam int CylBits = 16;
    localparam int TagBits = 16;
    localparam int IdxW    = (MaxReq > 1) ? $clog2(MaxReq) : 1;
    localparam int CntW    = $clog2(MaxReq + 1);
    localparam int KeyW    = (CylBits > IdxW) ? CylBits : IdxW;

    // Result queue depth.
    localparam int OutqDepth = 4;
    localparam int OutqPtrW  = $clog2(OutqDepth);

    // Configuration port.
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = CylBits;
    localparam logic [CfgIdxW-1:0] CfgPolicy = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgStart  = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgSweep  = 2'd2;

    // Policy codes.
    localparam logic [2:0] PolFcfs  = 3'd0;
    localparam logic [2:0] PolSstf  = 3'd1;
    localparam logic [2:0] PolLstf  = 3'd2;
    localparam logic [2:0] PolLcfs  = 3'd3;
    localparam logic [2:0] PolScan  = 3'd4;
    localparam logic [2:0] PolCscan = 3'd5;
    localparam logic [2:0] PolLook  = 3'd6;
    localparam logic [2:0] PolClook = 3'd7;

    // Input beat.
    typedef struct packed {
        logic [CylBits-1:0] cylinder;
        logic [TagBits-1:0] page_tag;
        logic               batch_end;
    } t_req;

    // Result beat.
    typedef struct packed {
        logic [TagBits-1:0] served_tag;
        logic               final_res;
    } t_res;

    // Configuration registers as seen by the ordering engine.
    typedef struct packed {
        logic [2:0]         policy;
        logic [CylBits-1:0] start_cylinder;
        logic               sweep_up;
    } t_cfg;

    // Store write from the loader.
    typedef struct packed {
        logic               we;
        logic [IdxW-1:0]    addr;
        logic [CylBits-1:0] cyl;
        logic [TagBits-1:0] tag;
    } t_wr;

    // Batch handed from the loader to the ordering engine.
    typedef struct packed {
        logic            valid;
        logic [CntW-1:0] count;
    } t_job;

    // Engine status back to the loader.
    typedef struct packed {
        logic take;
        logic done;
    } t_eng_st;

endpackage
`default_nettype wire

>>> rtl/drs_front.sv
// Request loader: counts requests, writes the store and hands off closed batches.
`timescale 1ns / 1ps
`default_nettype none
module drs_front
    import drs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    output logic         o_full,
    input  wire t_req    i_req,
    output t_wr          o_wr,
    output t_job         o_job,
    input  wire t_eng_st i_eng
);

    logic [CntW-1:0] r_count, n_count;
    logic            r_busy, n_busy;
    t_job            r_job, n_job;
    logic            accept;
    logic            has_room;

    assign accept   = i_push && !r_busy;
    assign has_room = (r_count < CntW'(MaxReq));

    // Store write for an accepted request while there is room.
    always_comb begin
        o_wr.we   = accept && has_room;
        o_wr.addr = r_count[IdxW-1:0];
        o_wr.cyl  = i_req.cylinder;
        o_wr.tag  = i_req.page_tag;
    end

    // Batch bookkeeping: the loader stalls from batch end until the engine finishes.
    always_comb begin
        n_count = r_count;
        n_busy  = r_busy;
        n_job   = r_job;
        if (i_eng.take) begin
            n_job.valid = 1'b0;
        end
        if (i_eng.done) begin
            n_busy = 1'b0;
        end
        if (accept) begin
            if (i_req.batch_end) begin
                n_job.valid = 1'b1;
                n_job.count = has_room ? r_count + CntW'(1) : r_count;
                n_count     = '0;
                n_busy      = 1'b1;
            end else if (has_room) begin
                n_count = r_count + CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
            r_job   <= '0;
        end else begin
            r_count <= n_count;
            r_busy  <= n_busy;
            r_job   <= n_job;
        end
    end

    assign o_full = r_busy;
    assign o_job  = r_job;

endmodule
`default_nettype wire

>>> rtl/drs_back.sv
// Ordering engine: request store and the scan sequencer that picks the next request.
`timescale 1ns / 1ps
`default_nettype none
module drs_back
    import drs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire t_wr  i_wr,
    input  wire t_job i_job,
    output t_eng_st   o_eng,
    output logic      o_push,
    output t_res      o_res,
    input  wire logic i_q_full
);

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StScan = 2'd1;
    localparam logic [1:0] StRead = 2'd2;
    localparam logic [1:0] StEmit = 2'd3;

    logic [CylBits-1:0] cyl_mem [MaxReq];
    logic [TagBits-1:0] tag_mem [MaxReq];

    logic [1:0]         r_state, n_state;
    logic [CntW-1:0]    r_n, n_n;
    logic [CntW-1:0]    r_served, n_served;
    logic               r_phase, n_phase;
    logic [CntW-1:0]    r_addr, n_addr;
    logic               r_pv, n_pv;
    logic [IdxW-1:0]    r_pidx, n_pidx;
    logic               r_found, n_found;
    logic [KeyW-1:0]    r_bkey, n_bkey;
    logic [IdxW-1:0]    r_bidx, n_bidx;
    logic [CylBits-1:0] r_pos, n_pos;
    logic [MaxReq-1:0]  r_done, n_done;
    logic [CylBits-1:0] r_rd_cyl;
    logic [TagBits-1:0] r_rd_tag;
    logic [IdxW-1:0]    rd_addr;

    logic               is_seek, is_sweep, cyclic, first_up;
    logic               want_up, asc, maximize, side_ok, cand_ok, better;
    logic [CylBits-1:0] seek_gap;
    logic [KeyW-1:0]    key;
    logic               last_pick;

    // Store: one write port from the loader, one registered read port.
    assign rd_addr = (r_state == StScan) ? r_addr[IdxW-1:0] : r_bidx;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            cyl_mem[i_wr.addr] <= i_wr.cyl;
            tag_mem[i_wr.addr] <= i_wr.tag;
        end
        r_rd_cyl <= cyl_mem[rd_addr];
        r_rd_tag <= tag_mem[rd_addr];
    end

    // Pick criteria of the current policy and sweep phase.
    always_comb begin
        is_seek  = (i_cfg.policy == PolSstf) || (i_cfg.policy == PolLstf);
        is_sweep = i_cfg.policy[2];
        cyclic   = (i_cfg.policy == PolCscan) || (i_cfg.policy == PolClook);
        first_up = cyclic || i_cfg.sweep_up;
        want_up  = r_phase ? !first_up : first_up;
        asc      = cyclic || want_up;
        maximize = (i_cfg.policy == PolLstf) || (i_cfg.policy == PolLcfs)
                   || (is_sweep && !asc);
        seek_gap = (r_rd_cyl > r_pos) ? r_rd_cyl - r_pos : r_pos - r_rd_cyl;
        if (is_seek) begin
            key = KeyW'(seek_gap);
        end else if (is_sweep) begin
            key = KeyW'(r_rd_cyl);
        end else begin
            key = KeyW'(r_pidx);
        end
        side_ok  = !is_sweep || ((r_rd_cyl >= i_cfg.start_cylinder) == want_up);
        cand_ok  = r_pv && !r_done[r_pidx] && side_ok;
        better   = !r_found || (maximize ? (key > r_bkey) : (key < r_bkey));
    end

    assign last_pick = (r_served + CntW'(1)) == r_n;

    // Sequencer: scan the batch for each pick (again after a sweep turn), then read and emit the winner.
    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_served = r_served;
        n_phase  = r_phase;
        n_addr   = r_addr;
        n_pv     = 1'b0;
        n_pidx   = r_pidx;
        n_found  = r_found;
        n_bkey   = r_bkey;
        n_bidx   = r_bidx;
        n_pos    = r_pos;
        n_done   = r_done;
        o_eng    = '0;
        o_push   = 1'b0;
        o_res.served_tag = r_rd_tag;
        o_res.final_res  = last_pick;
        case (r_state)
            StIdle: begin
                if (i_job.valid) begin
                    o_eng.take = 1'b1;
                    n_n        = i_job.count;
                    n_served   = '0;
                    n_phase    = 1'b0;
                    n_addr     = '0;
                    n_found    = 1'b0;
                    n_pos      = i_cfg.start_cylinder;
                    n_done     = '0;
                    n_state    = StScan;
                end
            end
            StScan: begin
                if (cand_ok && better) begin
                    n_found = 1'b1;
                    n_bkey  = key;
                    n_bidx  = r_pidx;
                end
                if (r_addr < r_n) begin
                    n_pv   = 1'b1;
                    n_pidx = r_addr[IdxW-1:0];
                    n_addr = r_addr + CntW'(1);
                end else if (!r_pv) begin
                    n_addr = '0;
                    if (r_found) begin
                        n_state = StRead;
                    end else if (!r_phase) begin
                        n_phase = 1'b1;
                    end else begin
                        o_eng.done = 1'b1;
                        n_state    = StIdle;
                    end
                end
            end
            StRead: begin
                n_state = StEmit;
            end
            StEmit: begin
                if (!i_q_full) begin
                    o_push         = 1'b1;
                    n_done[r_bidx] = 1'b1;
                    n_pos          = r_rd_cyl;
                    n_served       = r_served + CntW'(1);
                    n_found        = 1'b0;
                    n_addr         = '0;
                    if (last_pick) begin
                        o_eng.done = 1'b1;
                        n_state    = StIdle;
                    end else begin
                        n_state = StScan;
                    end
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= StIdle;
            r_served <= '0;
            r_phase  <= 1'b0;
            r_addr   <= '0;
            r_pv     <= 1'b0;
            r_found  <= 1'b0;
            r_done   <= '0;
        end else begin
            r_state  <= n_state;
            r_served <= n_served;
            r_phase  <= n_phase;
            r_addr   <= n_addr;
            r_pv     <= n_pv;
            r_found  <= n_found;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_pidx <= n_pidx;
        r_bkey <= n_bkey;
        r_bidx <= n_bidx;
        r_pos  <= n_pos;
    end

    // The engine never serves more requests than the batch holds.
    a_served_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != StIdle) |-> (r_served < r_n))
        else $error("served count reached batch size while busy");

    // A result beat goes out only when the result queue has room.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("result pushed into a full queue");

    // Finishing a batch returns the engine to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_eng.done |=> (r_state == StIdle))
        else $error("engine not idle after batch done");

    // A served request is marked so that no later scan picks it again.
    a_mark_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !last_pick) |=> r_done[$past(r_bidx)])
        else $error("served request not marked");

endmodule
`default_nettype wire

>>> rtl/drs_outq.sv
// Small result queue between the ordering engine and the result port.
`timescale 1ns / 1ps
`default_nettype none
module drs_outq
    import drs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_res i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_res      o_data
);

    t_res                r_mem [OutqDepth];
    logic [OutqPtrW-1:0] r_wp, r_rp;
    logic [OutqPtrW:0]   r_cnt;
    logic                do_push, do_pop;

    assign o_full  = (r_cnt == (OutqPtrW+1)'(OutqDepth));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + OutqPtrW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + OutqPtrW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (OutqPtrW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (OutqPtrW+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/disk_request_order_scheduler.sv
// Top level of the disk request order scheduler: configuration registers and wiring.
//
//  Port group          Direction  Beat
//  push/full/i_req     in         one request (cylinder, page tag, batch end)
//  pop/empty/o_res     out        one served tag with its final flag
//  i_cfg_*             in         register write (policy, start cylinder, sweep)
//
// A request that does not end a batch is taken in the cycle it is pushed while full is low.
// After batch end, full stays high until the last result has entered the result queue.
// Each result costs at least one scan of the n stored requests in the ordering
// engine; a sweep policy scans again when it turns to the other side.
// A full result queue stalls the engine; reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module disk_request_order_scheduler
    import drs_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire t_req                i_req,
    input  wire logic                pop,
    output logic                     empty,
    output t_res                     o_res,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [CfgDataW-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_wr     wr;
    t_job    job;
    t_eng_st eng;
    logic    q_push;
    logic    q_full;
    t_res    q_data;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.policy         <= PolFcfs;
            r_cfg.start_cylinder <= '0;
            r_cfg.sweep_up       <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgPolicy: r_cfg.policy         <= i_cfg_data[2:0];
                CfgStart:  r_cfg.start_cylinder <= i_cfg_data[CylBits-1:0];
                CfgSweep:  r_cfg.sweep_up       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    drs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_req   (i_req),
        .o_wr    (wr),
        .o_job   (job),
        .i_eng   (eng)
    );

    drs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_wr     (wr),
        .i_job    (job),
        .o_eng    (eng),
        .o_push   (q_push),
        .o_res    (q_data),
        .i_q_full (q_full)
    );

    drs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_data),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_res)
    );

endmodule
`default_nettype wire

>>> verif/drs_order_checker.sv
// Checker for the disk request order scheduler: predicts the service order and compares results.
`timescale 1ns / 1ps
`default_nettype none
module drs_order_checker
    import drs_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    input  wire logic                full,
    input  wire t_req                i_req,
    input  wire logic                pop,
    input  wire logic                empty,
    input  wire t_res                o_res,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending
);

    // Mirror of the registers and the request store.
    logic [2:0]         cur_policy;
    logic [CylBits-1:0] cur_start;
    logic               cur_sweep_up;
    logic [CylBits-1:0] cyl_mem [MaxReq];
    logic [TagBits-1:0] tag_mem [MaxReq];
    bit                 served [MaxReq];
    int                 batch_size;
    t_res               order_q [$];
    int                 mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = order_q.size();

    function automatic logic [CylBits-1:0] cyl_gap(logic [CylBits-1:0] a,
                                                   logic [CylBits-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Queues one served tag and marks its entry done.
    function automatic void serve_entry(int idx, ref logic [CylBits-1:0] head);
        t_res r;
        served[idx] = 1'b1;
        head = cyl_mem[idx];
        r.served_tag = tag_mem[idx];
        r.final_res = 1'b0;
        order_q.push_back(r);
    endfunction

    // Serves every request on one side of the start cylinder in sorted order.
    function automatic void sweep_side(bit upper, bit ascending, ref logic [CylBits-1:0] head);
        int best;
        while (1) begin
            best = -1;
            for (int i = 0; i < batch_size; i++) begin
                if (served[i] || ((cyl_mem[i] >= cur_start) != upper)) continue;
                if (best < 0 || (ascending ? cyl_mem[i] < cyl_mem[best]
                                           : cyl_mem[i] > cyl_mem[best])) best = i;
            end
            if (best < 0) break;
            serve_entry(best, head);
        end
    endfunction

    // Works out the service order of the stored batch.
    function automatic void order_batch();
        logic [CylBits-1:0] head;
        int best;
        int before_cnt;
        before_cnt = order_q.size();
        head = cur_start;
        for (int i = 0; i < MaxReq; i++) served[i] = 1'b0;
        case (cur_policy)
            PolFcfs: for (int i = 0; i < batch_size; i++) serve_entry(i, head);
            PolLcfs: for (int i = batch_size - 1; i >= 0; i--) serve_entry(i, head);
            PolSstf, PolLstf: begin
                for (int k = 0; k < batch_size; k++) begin
                    best = -1;
                    for (int i = 0; i < batch_size; i++) begin
                        if (served[i]) continue;
                        if (best < 0) best = i;
                        else if (cur_policy == PolLstf ?
                                 cyl_gap(cyl_mem[i], head) > cyl_gap(cyl_mem[best], head) :
                                 cyl_gap(cyl_mem[i], head) < cyl_gap(cyl_mem[best], head))
                            best = i;
                    end
                    serve_entry(best, head);
                end
            end
            PolScan, PolLook: begin
                if (cur_sweep_up) begin
                    sweep_side(1'b1, 1'b1, head);
                    sweep_side(1'b0, 1'b0, head);
                end else begin
                    sweep_side(1'b0, 1'b0, head);
                    sweep_side(1'b1, 1'b1, head);
                end
            end
            default: begin
                sweep_side(1'b1, 1'b1, head);
                sweep_side(1'b0, 1'b1, head);
            end
        endcase
        if (order_q.size() > before_cnt) order_q[$].final_res = 1'b1;
        batch_size = 0;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            cur_policy   <= PolFcfs;
            cur_start    <= '0;
            cur_sweep_up <= 1'b1;
            batch_size = 0;
            mismatches = 0;
            order_q.delete();
        end else begin
            // Result beat is checked against the oldest expectation.
            if (pop && !empty) begin
                if (order_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result tag=%h final=%b",
                                 o_res.served_tag, o_res.final_res);
                end else begin
                    want = order_q.pop_front();
                    if (want !== o_res) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected tag=%h final=%b, got tag=%h final=%b",
                                     want.served_tag, want.final_res,
                                     o_res.served_tag, o_res.final_res);
                    end
                end
            end
            // Request beat: store, and order on batch end.
            if (push && !full) begin
                if (batch_size < MaxReq) begin
                    cyl_mem[batch_size] = i_req.cylinder;
                    tag_mem[batch_size] = i_req.page_tag;
                    batch_size++;
                end
                if (i_req.batch_end) order_batch();
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgPolicy: cur_policy   <= i_cfg_data[2:0];
                    CfgStart:  cur_start    <= i_cfg_data;
                    CfgSweep:  cur_sweep_up <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

>>> verif/tb_disk_request_order_scheduler.sv
// Testbench top for the disk request order scheduler: stimulus, pop pacing and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_disk_request_order_scheduler;
    import drs_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                push;
    logic                full;
    t_req                i_req;
    logic                pop;
    logic                empty;
    t_res                o_res;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;
    int                  fail_count;
    int                  pending;
    bit                  hold_pop;
    int                  sent;

    disk_request_order_scheduler DUT (
        .i_clk, .i_rst_n, .push, .full, .i_req, .pop, .empty, .o_res,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    drs_order_checker u_checker (
        .i_clk, .i_rst_n, .push, .full, .i_req, .pop, .empty, .o_res,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // Short gaps mostly, a long one now and then.
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Offers one request beat and holds it until it is taken.
    task automatic send_req(logic [CylBits-1:0] cyl, logic [TagBits-1:0] tag, logic last);
        push            <= 1'b1;
        i_req.cylinder  <= cyl;
        i_req.page_tag  <= tag;
        i_req.batch_end <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sent++;
    endtask

    task automatic idle_gap();
        int g;
        g = gap_len();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Waits until every predicted result is out, then lets the engine settle.
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || !empty) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic rand_cfg();
        write_reg(CfgPolicy, CfgDataW'($urandom_range(0, 7)));
        case ($urandom_range(0, 3))
            0: write_reg(CfgStart, '0);
            1: write_reg(CfgStart, '1);
            default: write_reg(CfgStart, CfgDataW'($urandom));
        endcase
        write_reg(CfgSweep, CfgDataW'($urandom_range(0, 1)));
    endtask

    // One batch of n requests; cylinders sometimes squeezed into 0 to 6 for ties.
    task automatic send_batch(int n, bit narrow, bit gaps);
        logic [CylBits-1:0] c;
        for (int i = 0; i < n; i++) begin
            c = narrow ? CylBits'($urandom_range(0, 6)) : CylBits'($urandom);
            send_req(c, TagBits'($urandom), i == n - 1);
            if (gaps) idle_gap();
        end
    endtask

    // Receiver: random pop gaps, stalled entirely while hold_pop is set.
    initial begin
        int g;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pop) pop <= 1'b0;
            else begin
                g = gap_len();
                if (g > 0) begin
                    pop <= 1'b0;
                    repeat (g - 1) @(posedge i_clk);
                end
                pop <= 1'b1;
                while ($urandom_range(0, 3) != 0 && !hold_pop) @(posedge i_clk);
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        push       <= 1'b0;
        i_req      <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        hold_pop   = 1'b0;
        sent       = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset policy with field extremes and a one-entry batch.
        send_req('0, '0, 1'b0);
        send_req('1, '1, 1'b0);
        send_req(16'h8000, 16'h5555, 1'b1);
        send_req(16'h0001, 16'haaaa, 1'b1);
        drain();
        // Every policy, sweep direction from the policy's low bit, head at the middle with ties on it.
        for (int p = 0; p < 8; p++) begin
            write_reg(CfgPolicy, CfgDataW'(p));
            write_reg(CfgStart, 16'd3);
            write_reg(CfgSweep, CfgDataW'(p[0]));
            send_req(16'd3, 16'd10, 1'b0);
            send_req(16'd1, 16'd11, 1'b0);
            send_req(16'd5, 16'd12, 1'b0);
            send_req(16'd3, 16'd13, 1'b0);
            send_req(16'd1, 16'd14, 1'b1);
            drain();
        end
        // Overfull batch: the extra requests are dropped, batch end still orders.
        write_reg(CfgPolicy, CfgDataW'(PolLcfs));
        send_batch(MaxReq + 3, 1'b0, 1'b0);
        drain();

        // Long receiver stall while the sender keeps pushing.
        fork
            begin
                hold_pop = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_pop = 1'b0;
            end
            send_batch(8, 1'b0, 1'b0);
        join
        drain();

        // Random batches, mostly small, under changing settings.
        while (sent < 410) begin
            rand_cfg();
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 9))
                    0: send_batch(MaxReq + $urandom_range(0, 2), 1'b0, 1'b1);
                    1, 2: send_batch($urandom_range(1, 8), 1'b1, 1'b1);
                    default: send_batch($urandom_range(1, 10), 1'b0, $urandom_range(0, 1));
                endcase
            end
            drain();
        end

        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
rtl/drs_pkg.sv
rtl/drs_front.sv
rtl/drs_back.sv
rtl/drs_outq.sv
rtl/disk_request_order_scheduler.sv
verif/drs_order_checker.sv
verif/tb_disk_request_order_scheduler.sv
